@@ hw/rtl/interval_value_map_top_assert.svh @@
// Assertion macros used by the checker file of the interval value map.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef INTERVAL_VALUE_MAP_TOP_ASSERT_SVH
`define INTERVAL_VALUE_MAP_TOP_ASSERT_SVH

`define IVM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define IVM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/ivm_pkg.sv @@
// Package of the interval value map: request and result types and status codes.
// No dependencies.
`default_nettype none
package ivm_pkg;

    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 8;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        OP_ASSIGN = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef struct packed {
        logic                        operation;
        logic signed [KEY_BITS-1:0]  range_begin;
        logic signed [KEY_BITS-1:0]  range_end;
        logic [VALUE_BITS-1:0]       new_value;
        logic signed [KEY_BITS-1:0]  query_key;
    } ivm_req_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] read_value;
        logic [1:0]            status;
        logic [4:0]            entry_count;
    } ivm_res_t;

endpackage
`default_nettype wire

@@ hw/rtl/interval_value_map_top.sv @@
// Top level of the interval value map: control sequencer, two table banks, APB register.
// Depends on ivm_pkg and ivm_ram.
//
// The breakpoint table lives in two RAM banks; an assign copies the active bank into
// the other one while splicing in the new interval and merging repeated values, and
// flips banks only if the result fits, so a rejected assign leaves the table intact.
// Every table entry takes a read-issue step and then a decision step on the single
// read port. An empty interval skips the table. A new request is taken as soon as
// the previous result has moved into the output register.
`default_nettype none
module interval_value_map_top #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire ivm_pkg::ivm_req_t in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output ivm_pkg::ivm_res_t     out_data,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready
);
    import ivm_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int MW = $clog2(MAX_ENTRIES + 3);
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int EW = KEY_BITS + VALUE_BITS;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_LREAD  = 10'b0000000010,
        ST_LPROC  = 10'b0000000100,
        ST_EREAD  = 10'b0000001000,
        ST_EPROC  = 10'b0000010000,
        ST_CREAD  = 10'b0000100000,
        ST_CPROC  = 10'b0001000000,
        ST_INSB   = 10'b0010000000,
        ST_INSE   = 10'b0100000000,
        ST_FINISH = 10'b1000000000
    } state_t;

    state_t                state_reg, state_next;
    logic                  sel_reg, sel_next;
    logic [CW-1:0]         used_reg, used_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [MW-1:0]         cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] prev_reg, prev_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  ins_reg, ins_next;
    status_t               st_reg, st_next;
    ivm_req_t              req_reg, req_next;
    logic                  ov_reg, ov_next;
    ivm_res_t              res_reg, res_next;
    logic [VALUE_BITS-1:0] dflt_reg;

    logic                  emit;
    logic [KEY_BITS-1:0]   emit_key;
    logic [VALUE_BITS-1:0] emit_val;
    logic                  wr_en;
    logic [EW-1:0]         rd0, rd1, rd;
    logic signed [KEY_BITS-1:0] ent_key, scan_key;
    logic [VALUE_BITS-1:0] ent_val;
    logic                  accept;

    ivm_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_bank0 (
        .clk(clk), .we(wr_en && sel_reg), .waddr(cnt_reg[AW-1:0]),
        .wdata({emit_key, emit_val}), .raddr(idx_reg[AW-1:0]), .rdata(rd0)
    );
    ivm_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_bank1 (
        .clk(clk), .we(wr_en && !sel_reg), .waddr(cnt_reg[AW-1:0]),
        .wdata({emit_key, emit_val}), .raddr(idx_reg[AW-1:0]), .rdata(rd1)
    );

    assign rd       = sel_reg ? rd1 : rd0;
    assign ent_key  = rd[EW-1:VALUE_BITS];
    assign ent_val  = rd[VALUE_BITS-1:0];
    assign scan_key = (req_reg.operation == OP_LOOKUP) ? req_reg.query_key : req_reg.range_end;
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign out_data  = res_reg;
    assign pready    = 1'b1;
    assign prdata    = paddr[2] ? 32'd0 : {{(32 - VALUE_BITS){1'b0}}, dflt_reg};
    assign wr_en     = emit && (emit_val != prev_reg) && (cnt_reg < MW'(MAX_ENTRIES));

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        used_next  = used_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        prev_next  = prev_reg;
        acc_next   = acc_reg;
        ins_next   = ins_reg;
        st_next    = st_reg;
        req_next   = req_reg;
        ov_next    = ov_reg && out_stall;
        res_next   = res_reg;
        emit       = 1'b0;
        emit_key   = ent_key;
        emit_val   = ent_val;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next = in_data;
                    idx_next = '0;
                    acc_next = dflt_reg;
                    st_next  = STATUS_DONE;
                    if (in_data.operation == OP_LOOKUP)
                    begin
                        state_next = ST_LREAD;
                    end
                    else if (in_data.range_begin >= in_data.range_end)
                    begin
                        st_next    = STATUS_EMPTY;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_EREAD;
                    end
                end
            end
            ST_LREAD, ST_EREAD:
            begin
                if (idx_reg < used_reg)
                begin
                    state_next = (state_reg == ST_LREAD) ? ST_LPROC : ST_EPROC;
                end
                else if (state_reg == ST_LREAD)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next   = '0;
                    cnt_next   = '0;
                    prev_next  = dflt_reg;
                    ins_next   = 1'b0;
                    state_next = ST_CREAD;
                end
            end
            ST_LPROC, ST_EPROC:
            begin
                if (ent_key <= scan_key)
                begin
                    acc_next   = ent_val;
                    idx_next   = idx_reg + 1'b1;
                    state_next = (state_reg == ST_LPROC) ? ST_LREAD : ST_EREAD;
                end
                else
                begin
                    idx_next   = used_reg;
                    state_next = (state_reg == ST_LPROC) ? ST_LREAD : ST_EREAD;
                end
            end
            ST_CREAD:
            begin
                if (idx_reg < used_reg)
                begin
                    state_next = ST_CPROC;
                end
                else if (!ins_reg)
                begin
                    state_next = ST_INSB;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_CPROC:
            begin
                if (ent_key < req_reg.range_begin)
                begin
                    emit       = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_CREAD;
                end
                else if (!ins_reg)
                begin
                    state_next = ST_INSB;
                end
                else
                begin
                    emit       = (ent_key > req_reg.range_end);
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_CREAD;
                end
            end
            ST_INSB:
            begin
                emit       = 1'b1;
                emit_key   = req_reg.range_begin;
                emit_val   = req_reg.new_value;
                state_next = ST_INSE;
            end
            ST_INSE:
            begin
                emit       = 1'b1;
                emit_key   = req_reg.range_end;
                emit_val   = acc_reg;
                ins_next   = 1'b1;
                state_next = ST_CREAD;
            end
            ST_FINISH:
            begin
                if (!ov_reg || !out_stall)
                begin
                    res_next.read_value  = '0;
                    res_next.status      = st_reg;
                    res_next.entry_count = 5'(used_reg);
                    if (req_reg.operation == OP_LOOKUP)
                    begin
                        res_next.read_value = acc_reg;
                    end
                    else if (st_reg == STATUS_DONE)
                    begin
                        if (cnt_reg > MW'(MAX_ENTRIES))
                        begin
                            res_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            sel_next             = !sel_reg;
                            used_next            = cnt_reg[CW-1:0];
                            res_next.entry_count = 5'(cnt_reg);
                        end
                    end
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (emit)
        begin
            prev_next = emit_val;
            if (emit_val != prev_reg)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= 1'b0;
            used_reg  <= '0;
            ov_reg    <= 1'b0;
            dflt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            used_reg  <= used_next;
            ov_reg    <= ov_next;
            if (psel && penable && pwrite && !paddr[2])
            begin
                dflt_reg <= pwdata[VALUE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
        prev_reg <= prev_next;
        acc_reg  <= acc_next;
        ins_reg  <= ins_next;
        st_reg   <= st_next;
        req_reg  <= req_next;
        res_reg  <= res_next;
    end
endmodule
`default_nettype wire

@@ hw/rtl/ivm_ram.sv @@
// Generic single write port RAM with one registered read port.
// No dependencies.
`default_nettype none
module ivm_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/ivm_checker.sv @@
// Port-level checker for the interval value map, bound to the top level.
// Depends on ivm_pkg and interval_value_map_top_assert.svh.
`default_nettype none
`include "interval_value_map_top_assert.svh"
module ivm_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire ivm_pkg::ivm_res_t out_data
);
    import ivm_pkg::*;

    `IVM_ASSERT_NEXT(a_hold_payload, out_valid && out_stall, $stable(out_data))
    `IVM_ASSERT_NEXT(a_busy_after_request, in_valid && !in_stall, in_stall)
    `IVM_ASSERT_SAME(a_empty_reads_zero, out_valid && out_data.status == STATUS_EMPTY,
        out_data.read_value == '0)
    `IVM_ASSERT_SAME(a_status_code, out_valid, out_data.status <= 2'(STATUS_FULL))
endmodule

bind interval_value_map_top ivm_checker u_ivm_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
